### sv/command_line_assembler_queue_unit_macros.svh
// Assertion macros for the command line assembler queue.
// Used by command_line_assembler_queue_unit; depends on nothing else.
`ifndef COMMAND_LINE_ASSEMBLER_QUEUE_UNIT_MACROS_SVH
`define COMMAND_LINE_ASSEMBLER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/clq_pkg.sv
// Shared types, constants and helpers for the command line assembler queue.
// Used by command_line_assembler_queue_unit; depends on nothing.
package clq_pkg;

   localparam int LINE_MAX   = 64;
   localparam int LINE_CHARS = LINE_MAX - 1;
   localparam int SLOTS      = 8;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int POS_W      = $clog2(LINE_MAX);
   localparam int LEN_W      = POS_W;
   localparam int ADDR_W     = SLOT_W + POS_W;
   localparam int MEM_DEPTH  = SLOTS * LINE_MAX;
   localparam int CHAR_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int CAP_W      = 7;
   localparam int CAP_MAX    = 64;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(CAP_MAX);
   localparam logic [BYTE_W-1:0] BYTE_LF   = 8'd10;
   localparam logic [BYTE_W-1:0] BYTE_CR   = 8'd13;
   localparam logic [BYTE_W-1:0] PRINT_LO  = 8'd32;
   localparam logic [BYTE_W-1:0] PRINT_HI  = 8'd126;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic              found;
      logic              has_char;
      logic [CHAR_W-1:0] character;
      logic              last;
   } rsp_type;

   function automatic logic [LEN_W-1:0] cap_limit(input logic [CAP_W-1:0] cap);
      logic [LEN_W-1:0] lim;
      if (cap == '0) begin
         lim = '0;
      end else if (cap > CAP_W'(CAP_MAX)) begin
         lim = LEN_W'(CAP_MAX - 1);
      end else begin
         lim = LEN_W'(cap - 1'b1);
      end
      return lim;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W-1:0] nxt;
      if (idx == SLOT_W'(SLOTS - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

endpackage

### sv/clq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Used by command_line_assembler_queue_unit for the slot characters; no dependencies.
module clq_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/command_line_assembler_queue_unit.sv
// Top level of the command line assembler queue: line assembly, slot ring, take streaming.
// Depends on clq_pkg, clq_ram and command_line_assembler_queue_unit_macros.svh.
//
//   channel  direction  handshake       payload
//   req_     in         valid / stall   req_type: operation, data_byte
//   rsp_     out        valid / stall   rsp_type: found, has_char, character, last
//   csr_     in         valid / ready   out_capacity, 7 bits
//
// Pushes are accepted back to back while no take is in progress.
// A take holds req_stall until its last response loads; its characters come one per cycle,
// unless rsp_stall holds, through the single read port of the character RAM.
// Lines assemble in place in the slot at write_index, so finishing a line copies nothing.
// Synchronous reset clears indices, line length and state, sets capacity to 64; RAM needs no clearing.
// rsp_stall holds the output register and pauses RAM reads; no result is lost.
`include "command_line_assembler_queue_unit_macros.svh"

module command_line_assembler_queue_unit
   import clq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [LEN_W-1:0]  line_len_ff, line_len_in;
   logic [SLOT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0]  slot_len_ff [SLOTS];
   logic [SLOT_W-1:0] take_slot_ff, take_slot_in;
   logic              found_ff, found_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept, push, take;
   logic              is_eol, is_print, has_room;
   logic              enqueue, ring_busy;
   logic [SLOT_W-1:0] wr_next;
   logic [LEN_W-1:0]  take_len, take_lim, take_n;
   logic              rsp_free, load_single, load_stream, issue;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [CHAR_W-1:0] mem_q;

   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_data.operation == OP_PUSH);
   assign take      = accept && (req_data.operation == OP_TAKE);
   assign is_eol    = (req_data.data_byte == BYTE_LF) || (req_data.data_byte == BYTE_CR);
   assign is_print  = (req_data.data_byte >= PRINT_LO) && (req_data.data_byte <= PRINT_HI);
   assign has_room  = line_len_ff < LEN_W'(LINE_CHARS);
   assign wr_next   = slot_next(wr_idx_ff);
   assign enqueue   = push && is_eol && (line_len_ff != '0) && (wr_next != rd_idx_ff);
   assign ring_busy = rd_idx_ff != wr_idx_ff;
   assign take_len  = slot_len_ff[rd_idx_ff];
   assign take_lim  = cap_limit(cap_ff);
   assign take_n    = (take_len < take_lim) ? take_len : take_lim;

   assign mem_wr_en   = push && is_print && has_room;
   assign mem_wr_addr = {wr_idx_ff, line_len_ff};
   assign mem_rd_addr = {take_slot_ff, pos_ff};

   clq_ram #(
      .DEPTH (MEM_DEPTH),
      .WIDTH (CHAR_W)
   ) u_chars (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_data.data_byte[CHAR_W-1:0]),
      .rd_en   (issue),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = (ring_busy && (take_n != '0)) ? ST_STREAM : ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (load_single) begin
               state_in = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (load_stream && rd_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_free    = !rsp_valid_ff || !rsp_stall;
      req_stall   = 1'b1;
      load_single = 1'b0;
      load_stream = 1'b0;
      issue       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SINGLE: begin
            load_single = rsp_free;
         end
         ST_STREAM: begin
            load_stream = rd_pend_ff && rsp_free;
            issue       = (pos_ff != n_ff) && (!rd_pend_ff || load_stream);
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      cap_in       = (csr_valid && csr_ready) ? csr_data : cap_ff;
      line_len_in  = line_len_ff;
      wr_idx_in    = enqueue ? wr_next : wr_idx_ff;
      rd_idx_in    = (take && ring_busy) ? slot_next(rd_idx_ff) : rd_idx_ff;
      take_slot_in = take ? rd_idx_ff : take_slot_ff;
      found_in     = take ? ring_busy : found_ff;
      n_in         = take ? take_n : n_ff;
      pos_in       = take ? '0 : (issue ? pos_ff + 1'b1 : pos_ff);
      rd_pend_in   = issue || (rd_pend_ff && !load_stream);
      rd_last_in   = issue ? (LEN_W'(pos_ff + 1'b1) == n_ff) : rd_last_ff;
      if (push && is_eol) begin
         line_len_in = '0;
      end else if (mem_wr_en) begin
         line_len_in = line_len_ff + 1'b1;
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_single) begin
         rsp_in       = '{found: found_ff, has_char: 1'b0, character: '0, last: 1'b1};
         rsp_valid_in = 1'b1;
      end else if (load_stream) begin
         rsp_in       = '{found: 1'b1, has_char: 1'b1, character: mem_q, last: rd_last_ff};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         line_len_ff  <= '0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         line_len_ff  <= line_len_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      take_slot_ff <= take_slot_in;
      found_ff     <= found_in;
      n_ff         <= n_in;
      pos_ff       <= pos_in;
      rd_last_ff   <= rd_last_in;
      rsp_ff       <= rsp_in;
      if (enqueue) begin
         slot_len_ff[wr_idx_ff] <= line_len_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CLQ_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_wr_en, !issue, "character RAM written during a take")
   `CLQ_ASSERT_NOW(a_issue_in_range, clock, reset, issue, pos_ff < n_ff, "read issued past line end")
   `CLQ_ASSERT_NEXT(a_pend_held, clock, reset, rd_pend_ff && !load_stream, rd_pend_ff, "pending read data dropped")
   `CLQ_ASSERT_NEXT(a_take_frees, clock, reset, take && ring_busy, rd_idx_ff != $past(rd_idx_ff), "take did not free its slot")

endmodule
